### rtl/rarfp_pkg.sv
// Package for the remote AT command response frame parser.
// Holds frame offsets, field widths and the result record type.
// Used by rarfp_frame_state and remote_at_response_frame_parser_core.
package rarfp_pkg;

    localparam int unsigned PosW = 17;
    localparam int unsigned TdataW = 144;
    localparam int unsigned TdataPad = 6;

    localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
    localparam logic [PosW-1:0] PosLenHi = 17'd1;
    localparam logic [PosW-1:0] PosLenLo = 17'd2;
    localparam logic [PosW-1:0] PosSumStart = 17'd3;
    localparam logic [PosW-1:0] PosIdent = 17'd4;
    localparam logic [PosW-1:0] PosSrcFirst = 17'd5;
    localparam logic [PosW-1:0] PosSrcLast = 17'd12;
    localparam logic [PosW-1:0] PosNetFirst = 17'd13;
    localparam logic [PosW-1:0] PosNetLast = 17'd14;
    localparam logic [PosW-1:0] PosCmdFirst = 17'd15;
    localparam logic [PosW-1:0] PosCmdLast = 17'd16;
    localparam logic [PosW-1:0] PosStatus = 17'd17;
    localparam logic [PosW-1:0] PosParamFirst = 17'd18;
    localparam logic [PosW-1:0] LenOverhead = 17'd2;
    localparam logic [15:0] FixedPart = 16'd15;
    localparam logic [7:0] SumGood = 8'hFF;

    typedef struct packed {
        logic        param_valid;
        logic [7:0]  param_byte;
        logic        frame_done;
        logic [15:0] frame_length;
        logic [7:0]  frame_ident;
        logic [63:0] source_address;
        logic [15:0] network_address;
        logic [15:0] at_command;
        logic [7:0]  command_status;
        logic        checksum_ok;
        logic        frame_complete;
    } t_result;

endpackage

### rtl/remote_at_response_frame_parser_core.sv
// Top level of the remote AT command response frame parser.
// Streams frame bytes in, parameter bytes and a frame summary out.
// Depends on rarfp_pkg and rarfp_frame_state.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = data_byte, tlast = end_of_frame
//  m_axis    out        tdata = summary and parameter byte, tuser = param_valid,
//                       tlast = frame_done
//
// One byte is taken per cycle unless stalled; any result appears in the next cycle.
// The output register holds a result until it is taken, and a new byte is
// accepted whenever that register is empty or being drained in the same cycle.
// Reset is synchronous and active low and clears all frame state.
module remote_at_response_frame_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] param_byte, [23:8] frame_length, [31:24] frame_ident,
    // [95:32] source_address, [111:96] network_address, [127:112] at_command,
    // [135:128] command_status, [136] checksum_ok, [137] frame_complete, rest zero
    output logic [rarfp_pkg::TdataW-1:0] m_axis_tdata,
    output logic         m_axis_tuser,   // [0] param_valid
    output logic         m_axis_tlast
);

    logic               take;
    logic               emit;
    rarfp_pkg::t_result result;
    rarfp_pkg::t_result r_out;
    logic               r_out_valid;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;

    rarfp_frame_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.param_valid;
    assign m_axis_tlast  = r_out.frame_done;
    assign m_axis_tdata  = {{rarfp_pkg::TdataPad{1'b0}}, r_out.frame_complete,
                            r_out.checksum_ok, r_out.command_status, r_out.at_command,
                            r_out.network_address, r_out.source_address, r_out.frame_ident,
                            r_out.frame_length, r_out.param_byte};

    a_result_has_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("result without parameter byte or frame end");

    a_last_gives_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
        else $error("frame end did not produce a summary");

    a_no_param_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
        else $error("parameter byte set without parameter flag");

    a_summary_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[rarfp_pkg::TdataW-1:8] == '0)
        else $error("summary fields set before frame end");

endmodule

### rtl/rarfp_frame_state.sv
// Frame state of the parser: byte position, checksum and captured header fields.
// Forms the result record for each request from the stored state and the byte.
// Depends on rarfp_pkg.
module rarfp_frame_state (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic [7:0]               i_byte,
    input  logic                     i_last,
    output logic                     o_emit,
    output rarfp_pkg::t_result       o_result
);

    logic [rarfp_pkg::PosW-1:0] r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_length, n_length;
    logic [7:0]  r_ident, n_ident;
    logic [63:0] r_source, n_source;
    logic [15:0] r_network, n_network;
    logic [15:0] r_command, n_command;
    logic [7:0]  r_status, n_status;
    logic        param_hit;
    logic [rarfp_pkg::PosW-1:0] param_end;

    always_comb begin
        n_length  = r_length;
        n_ident   = r_ident;
        n_source  = r_source;
        n_network = r_network;
        n_command = r_command;
        n_status  = r_status;
        if (r_pos == rarfp_pkg::PosLenHi) begin
            n_length = {i_byte, r_length[7:0]};
        end else if (r_pos == rarfp_pkg::PosLenLo) begin
            n_length = {r_length[15:8], i_byte};
        end else if (r_pos == rarfp_pkg::PosIdent) begin
            n_ident = i_byte;
        end else if (r_pos >= rarfp_pkg::PosSrcFirst && r_pos <= rarfp_pkg::PosSrcLast) begin
            n_source = {r_source[55:0], i_byte};
        end else if (r_pos == rarfp_pkg::PosNetFirst || r_pos == rarfp_pkg::PosNetLast) begin
            n_network = {r_network[7:0], i_byte};
        end else if (r_pos == rarfp_pkg::PosCmdFirst || r_pos == rarfp_pkg::PosCmdLast) begin
            n_command = {r_command[7:0], i_byte};
        end else if (r_pos == rarfp_pkg::PosStatus) begin
            n_status = i_byte;
        end
        n_sum = (r_pos >= rarfp_pkg::PosSumStart) ? r_sum + i_byte : r_sum;
        n_pos = (r_pos != rarfp_pkg::PosMax) ? r_pos + 1'b1 : r_pos;
    end

    assign param_end = {1'b0, r_length} + rarfp_pkg::LenOverhead;
    assign param_hit = (r_pos >= rarfp_pkg::PosParamFirst) && (r_length > rarfp_pkg::FixedPart)
                       && (r_pos <= param_end);
    assign o_emit = param_hit || i_last;

    always_comb begin
        o_result = '0;
        o_result.param_valid = param_hit;
        o_result.param_byte  = param_hit ? i_byte : 8'h00;
        if (i_last) begin
            o_result.frame_done      = 1'b1;
            o_result.frame_length    = n_length;
            o_result.frame_ident     = n_ident;
            o_result.source_address  = n_source;
            o_result.network_address = n_network;
            o_result.at_command      = n_command;
            o_result.command_status  = n_status;
            o_result.checksum_ok     = (n_sum == rarfp_pkg::SumGood);
            o_result.frame_complete  = (r_pos >= rarfp_pkg::PosStatus);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_pos     <= '0;
            r_sum     <= '0;
            r_length  <= '0;
            r_ident   <= '0;
            r_source  <= '0;
            r_network <= '0;
            r_command <= '0;
            r_status  <= '0;
        end else if (i_take) begin
            r_pos     <= n_pos;
            r_sum     <= n_sum;
            r_length  <= n_length;
            r_ident   <= n_ident;
            r_source  <= n_source;
            r_network <= n_network;
            r_command <= n_command;
            r_status  <= n_status;
        end
    end

endmodule

### tb/rarfp_result_checker.sv
// Result checker for the remote AT command response frame parser.
// Predicts parameter bytes and frame summaries from accepted requests and compares them.
// Depends on rarfp_pkg for the frame offsets and the result record.
module rarfp_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [7:0]                    i_s_tdata,
    input  logic                          i_s_tlast,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [rarfp_pkg::TdataW-1:0]  i_m_tdata,
    input  logic                          i_m_tuser,
    input  logic                          i_m_tlast,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [rarfp_pkg::PosW-1:0] next_pos;
    logic [7:0]                 byte_sum;
    logic [15:0]                length_field;
    logic [7:0]                 ident_field;
    logic [63:0]                source_field;
    logic [15:0]                network_field;
    logic [15:0]                command_field;
    logic [7:0]                 status_field;

    rarfp_pkg::t_result param_and_summary_q[$];
    int                 mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic void clear_frame();
        next_pos = '0;
        byte_sum = '0;
        length_field = '0;
        ident_field = '0;
        source_field = '0;
        network_field = '0;
        command_field = '0;
        status_field = '0;
    endfunction

    function automatic void parse_frame_byte(logic [7:0] b, logic last);
        logic [rarfp_pkg::PosW-1:0] pos;
        logic                       pv;
        rarfp_pkg::t_result         res;
        pos = next_pos;
        if (pos == rarfp_pkg::PosLenHi) begin
            length_field[15:8] = b;
        end else if (pos == rarfp_pkg::PosLenLo) begin
            length_field[7:0] = b;
        end else if (pos == rarfp_pkg::PosIdent) begin
            ident_field = b;
        end else if (pos >= rarfp_pkg::PosSrcFirst && pos <= rarfp_pkg::PosSrcLast) begin
            source_field = {source_field[55:0], b};
        end else if (pos >= rarfp_pkg::PosNetFirst && pos <= rarfp_pkg::PosNetLast) begin
            network_field = {network_field[7:0], b};
        end else if (pos >= rarfp_pkg::PosCmdFirst && pos <= rarfp_pkg::PosCmdLast) begin
            command_field = {command_field[7:0], b};
        end else if (pos == rarfp_pkg::PosStatus) begin
            status_field = b;
        end
        if (pos >= rarfp_pkg::PosSumStart) begin
            byte_sum = byte_sum + b;
        end
        pv = (pos >= rarfp_pkg::PosParamFirst) && (length_field > rarfp_pkg::FixedPart)
            && (pos <= {1'b0, length_field} + rarfp_pkg::LenOverhead);
        if (next_pos != rarfp_pkg::PosMax) begin
            next_pos = next_pos + 1'b1;
        end
        if (pv || last) begin
            res = '0;
            res.param_valid = pv;
            res.param_byte = pv ? b : 8'h00;
            if (last) begin
                res.frame_done = 1'b1;
                res.frame_length = length_field;
                res.frame_ident = ident_field;
                res.source_address = source_field;
                res.network_address = network_field;
                res.at_command = command_field;
                res.command_status = status_field;
                res.checksum_ok = (byte_sum == rarfp_pkg::SumGood);
                res.frame_complete = (pos >= rarfp_pkg::PosStatus);
                clear_frame();
            end
            param_and_summary_q.push_back(res);
        end
    endfunction

    function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
            end
        end
    endfunction

    function automatic void check_result();
        rarfp_pkg::t_result want;
        if (param_and_summary_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result with none expected, tdata %0h", $realtime, i_m_tdata);
            end
            return;
        end
        want = param_and_summary_q.pop_front();
        compare_field("param_valid", 64'(want.param_valid), 64'(i_m_tuser));
        compare_field("param_byte", 64'(want.param_byte), 64'(i_m_tdata[7:0]));
        compare_field("frame_done", 64'(want.frame_done), 64'(i_m_tlast));
        compare_field("frame_length", 64'(want.frame_length), 64'(i_m_tdata[23:8]));
        compare_field("frame_ident", 64'(want.frame_ident), 64'(i_m_tdata[31:24]));
        compare_field("source_address", want.source_address, i_m_tdata[95:32]);
        compare_field("network_address", 64'(want.network_address), 64'(i_m_tdata[111:96]));
        compare_field("at_command", 64'(want.at_command), 64'(i_m_tdata[127:112]));
        compare_field("command_status", 64'(want.command_status), 64'(i_m_tdata[135:128]));
        compare_field("checksum_ok", 64'(want.checksum_ok), 64'(i_m_tdata[136]));
        compare_field("frame_complete", 64'(want.frame_complete), 64'(i_m_tdata[137]));
        compare_field("tdata padding", 64'h0, 64'(i_m_tdata[rarfp_pkg::TdataW-1:138]));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            param_and_summary_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result();
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_frame_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending <= param_and_summary_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb_top.sv
// Top of the frame parser testbench: clock, reset, byte stream and output stalls.
// Instantiates remote_at_response_frame_parser_core and rarfp_result_checker.
// Sends directed and random frames, then reports the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {CkGood, CkBad, CkRandom} t_ck_mode;
    typedef enum logic [1:0] {FillRandom, FillZero, FillOnes} t_fill;

    localparam int IdleLimit = 2000;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = 8'h00;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [rarfp_pkg::TdataW-1:0] m_axis_tdata;
    logic                         m_axis_tuser;
    logic                         m_axis_tlast;

    int fail_count;
    int pending;
    int bytes_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;

    remote_at_response_frame_parser_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rarfp_result_checker u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int gap_cycles();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 55) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left <= gap_cycles();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(logic [15:0] len, int nbytes, t_ck_mode ck, t_fill fill,
                              bit std_header);
        logic [7:0] b;
        logic [7:0] sum;
        sum = 8'h00;
        for (int i = 0; i < nbytes; i++) begin
            case (fill)
                FillZero: b = 8'h00;
                FillOnes: b = 8'hFF;
                default:  b = 8'($urandom_range(0, 255));
            endcase
            if (i == 0 && std_header) b = 8'h7E;
            if (i == 1) b = len[15:8];
            if (i == 2) b = len[7:0];
            if (i == 3 && std_header) b = 8'h97;
            if (i == nbytes - 1 && i >= 3) begin
                case (ck)
                    CkGood: b = 8'hFF - sum;
                    CkBad:  b = 8'hFF - sum + 8'($urandom_range(1, 255));
                    default: ;
                endcase
            end
            if (i >= 3) sum = sum + b;
            send_byte(b, i == nbytes - 1);
        end
    endtask

    initial begin
        int kind;
        int len;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_frame(16'h0000, 1, CkRandom, FillRandom, 1'b1);
        send_frame(16'hFFFF, 3, CkRandom, FillOnes, 1'b1);
        send_frame(16'h0020, 6, CkGood, FillRandom, 1'b1);
        send_frame(16'd15, 19, CkGood, FillZero, 1'b0);
        send_frame(16'd16, 20, CkGood, FillOnes, 1'b0);
        send_frame(16'd17, 20, CkGood, FillRandom, 1'b1);
        send_frame(16'hFFFF, 25, CkGood, FillRandom, 1'b1);
        send_frame(16'd0, 22, CkGood, FillRandom, 1'b1);
        send_frame(16'd20, 24, CkBad, FillRandom, 1'b1);
        send_frame(16'd18, 18, CkRandom, FillRandom, 1'b1);

        while (bytes_sent < 1200) begin
            idle_on = ($urandom_range(0, 4) != 0);
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                len = $urandom_range(15, 40);
                send_frame(16'(len), len + 4, ($urandom_range(0, 7) == 0) ? CkBad : CkGood,
                           FillRandom, 1'b1);
            end else if (kind == 7) begin
                send_frame(16'($urandom_range(0, 65535)), $urandom_range(1, 40), CkRandom,
                           FillRandom, 1'b0);
            end else if (kind == 8) begin
                len = $urandom_range(15, 30);
                send_frame(16'(len), $urandom_range(1, len + 8), CkRandom, FillRandom,
                           1'b0);
            end else begin
                send_frame(16'($urandom_range(0, 15)), $urandom_range(15, 30), CkGood,
                           FillRandom, 1'b1);
            end
        end

        idle_on = 1'b1;
        send_frame(16'd20, 24, CkGood, FillRandom, 1'b1);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
